>>> rtl/core/pay_pkg.sv
// pay_pkg: shared constants, register map and helpers for the palette
// ARGB to YCbCr converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pay_pkg;

    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned CFG9_W  = 9;

    // config register map, word index = paddr[ADDR_W-1:2]
    typedef enum logic [2:0] {
        REG_ALPHA_GAIN   = 3'd0,
        REG_ALPHA_OFFSET = 3'd1,
        REG_RGB_OUTPUT   = 3'd2,
        REG_TOP_LAYER    = 3'd3,
        REG_MIXER_FADE   = 3'd4,
        REG_MIXER_GRAY   = 3'd5
    } reg_idx_t;

    // BT.601 studio-range coefficients
    localparam logic [14:0] K_Y_R  = 15'd66;
    localparam logic [14:0] K_Y_G  = 15'd129;
    localparam logic [14:0] K_Y_B  = 15'd25;
    localparam logic [14:0] K_CB_R = 15'd38;
    localparam logic [14:0] K_CB_G = 15'd74;
    localparam logic [14:0] K_CB_B = 15'd112;
    localparam logic [14:0] K_CR_R = 15'd112;
    localparam logic [14:0] K_CR_G = 15'd94;
    localparam logic [14:0] K_CR_B = 15'd18;

    localparam logic [17:0] RND_HALF  = 18'd128;
    localparam logic [9:0]  Y_OFFSET  = 10'd16;
    localparam logic [9:0]  C_OFFSET  = 10'd128;
    localparam logic [9:0]  Y_MIN     = 10'd16;
    localparam logic [9:0]  Y_MAX     = 10'd235;
    localparam logic [9:0]  C_MIN     = 10'd16;
    localparam logic [9:0]  C_MAX     = 10'd240;
    localparam logic [7:0]  C_GRAY    = 8'h80;

    // floor(x/100) = (x * RECIP100) >> 24 for x < 2^16
    localparam logic [33:0] RECIP100  = 34'd167773;
    localparam int unsigned RECIP100_SH = 24;
    // floor(x/3) = (x * RECIP3) >> 11 for x < 2^11
    localparam logic [20:0] RECIP3    = 21'd683;
    localparam int unsigned RECIP3_SH = 11;

    // clamp a signed 10-bit value into [lo, hi], both within 0..255
    function automatic logic [7:0] clamp10(logic signed [9:0] x, logic [9:0] lo,
                                           logic [9:0] hi);
        logic [7:0] res;
        if (x < $signed(lo))
            res = lo[7:0];
        else if (x > $signed(hi))
            res = hi[7:0];
        else
            res = x[7:0];
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/palette_argb_to_ycbcr_top.sv
// Palette ARGB to YCbCr/RGB converter with alpha correction and layer mixer.
// Throughput 1 item/cycle while out_ready does not stall the output stage.
// Three register stages: products, sums and reciprocal divides, clamps and mixer.
// Output stage doubles as the output register; each stage holds under stall.
// rst_n async active low clears valid bits and config; rgb_output, top_layer set to 1.
// Depends on pay_pkg.
`timescale 1ns / 1ps
`default_nettype none

module palette_argb_to_ycbcr_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // APB config
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pay_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pay_pkg::DATA_W-1:0]   pwdata,
    output logic      [pay_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    // input items
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [7:0]                   in_alpha,
    input  wire logic [7:0]                   in_red,
    input  wire logic [7:0]                   in_green,
    input  wire logic [7:0]                   in_blue,
    input  wire logic                         in_last,
    // result items
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [7:0]                   out_first,
    output logic      [7:0]                   out_second,
    output logic      [7:0]                   out_third,
    output logic      [7:0]                   out_alpha,
    output logic                              out_last
);

    // ---------------- config registers ----------------
    logic signed [8:0] gain_reg;
    logic signed [8:0] offset_reg;
    logic              rgb_output_reg;
    logic              top_layer_reg;
    logic              mixer_fade_reg;
    logic              mixer_gray_reg;
    logic              cfg_wr;
    pay_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = pay_pkg::reg_idx_t'(paddr[pay_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg       <= '0;
            offset_reg     <= '0;
            rgb_output_reg <= 1'b1;
            top_layer_reg  <= 1'b1;
            mixer_fade_reg <= 1'b0;
            mixer_gray_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                pay_pkg::REG_ALPHA_GAIN:   gain_reg       <= $signed(pwdata[8:0]);
                pay_pkg::REG_ALPHA_OFFSET: offset_reg     <= $signed(pwdata[8:0]);
                pay_pkg::REG_RGB_OUTPUT:   rgb_output_reg <= pwdata[0];
                pay_pkg::REG_TOP_LAYER:    top_layer_reg  <= pwdata[0];
                pay_pkg::REG_MIXER_FADE:   mixer_fade_reg <= pwdata[0];
                pay_pkg::REG_MIXER_GRAY:   mixer_gray_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            pay_pkg::REG_ALPHA_GAIN:   prdata = {{(pay_pkg::DATA_W-9){gain_reg[8]}}, gain_reg};
            pay_pkg::REG_ALPHA_OFFSET: prdata = {{(pay_pkg::DATA_W-9){offset_reg[8]}},
                                                 offset_reg};
            pay_pkg::REG_RGB_OUTPUT:   prdata = {{(pay_pkg::DATA_W-1){1'b0}}, rgb_output_reg};
            pay_pkg::REG_TOP_LAYER:    prdata = {{(pay_pkg::DATA_W-1){1'b0}}, top_layer_reg};
            pay_pkg::REG_MIXER_FADE:   prdata = {{(pay_pkg::DATA_W-1){1'b0}}, mixer_fade_reg};
            pay_pkg::REG_MIXER_GRAY:   prdata = {{(pay_pkg::DATA_W-1){1'b0}}, mixer_gray_reg};
            default:                   prdata = '0;
        endcase
    end

    logic mix;
    assign mix = !top_layer_reg;

    // ---------------- stage handshake ----------------
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // ---------------- stage 1: products ----------------
    logic [7:0]  s1_alpha_reg;
    logic        s1_last_reg;
    logic [15:0] s1_gmag_reg;
    logic [9:0]  s1_rgbsum_reg;
    logic [14:0] s1_yr_reg, s1_yb_reg;
    logic [15:0] s1_yg_reg;
    logic [14:0] s1_cbr_reg, s1_cbg_reg, s1_cbb_reg;
    logic [14:0] s1_crr_reg, s1_crg_reg, s1_crb_reg;
    logic [7:0]  s1_red_reg, s1_green_reg, s1_blue_reg;

    logic [8:0]  gain_abs;
    logic [16:0] gmag_next;
    logic [14:0] r15, g15, b15;

    assign gain_abs  = gain_reg[8] ? 9'(-gain_reg) : 9'(gain_reg);
    assign gmag_next = 17'(gain_abs) * 17'(in_alpha);
    assign r15 = 15'(in_red);
    assign g15 = 15'(in_green);
    assign b15 = 15'(in_blue);

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_alpha_reg  <= in_alpha;
            s1_last_reg   <= in_last;
            s1_red_reg    <= in_red;
            s1_green_reg  <= in_green;
            s1_blue_reg   <= in_blue;
            s1_gmag_reg   <= gmag_next[15:0];
            s1_rgbsum_reg <= 10'(in_red) + 10'(in_green) + 10'(in_blue);
            s1_yr_reg     <= r15 * pay_pkg::K_Y_R;
            s1_yg_reg     <= 16'(in_green) * 16'(pay_pkg::K_Y_G);
            s1_yb_reg     <= b15 * pay_pkg::K_Y_B;
            s1_cbr_reg    <= r15 * pay_pkg::K_CB_R;
            s1_cbg_reg    <= g15 * pay_pkg::K_CB_G;
            s1_cbb_reg    <= b15 * pay_pkg::K_CB_B;
            s1_crr_reg    <= r15 * pay_pkg::K_CR_R;
            s1_crg_reg    <= g15 * pay_pkg::K_CR_G;
            s1_crb_reg    <= b15 * pay_pkg::K_CR_B;
        end
    end

    // ---------------- stage 2: sums, rounding, divides ----------------
    logic [7:0]        s2_alpha_reg;
    logic              s2_last_reg;
    logic [9:0]        s2_q100_reg;
    logic [7:0]        s2_avg_reg;
    logic [8:0]        s2_y_reg;
    logic signed [9:0] s2_cb_reg;
    logic signed [9:0] s2_cr_reg;
    logic [7:0]        s2_red_reg, s2_green_reg, s2_blue_reg;

    logic [33:0]        q100_full;
    logic [20:0]        avg_full;
    logic [17:0]        y_sum;
    logic signed [17:0] cb_sum;
    logic signed [17:0] cr_sum;

    assign q100_full = 34'(s1_gmag_reg) * pay_pkg::RECIP100;
    assign avg_full  = 21'(s1_rgbsum_reg) * pay_pkg::RECIP3;
    assign y_sum     = 18'(s1_yr_reg) + 18'(s1_yg_reg) + 18'(s1_yb_reg) + pay_pkg::RND_HALF;
    assign cb_sum    = $signed(18'(s1_cbb_reg)) - $signed(18'(s1_cbr_reg))
                     - $signed(18'(s1_cbg_reg)) + $signed(pay_pkg::RND_HALF);
    assign cr_sum    = $signed(18'(s1_crr_reg)) - $signed(18'(s1_crg_reg))
                     - $signed(18'(s1_crb_reg)) + $signed(pay_pkg::RND_HALF);

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_alpha_reg <= s1_alpha_reg;
            s2_last_reg  <= s1_last_reg;
            s2_red_reg   <= s1_red_reg;
            s2_green_reg <= s1_green_reg;
            s2_blue_reg  <= s1_blue_reg;
            s2_q100_reg  <= q100_full[pay_pkg::RECIP100_SH +: 10];
            s2_avg_reg   <= avg_full[pay_pkg::RECIP3_SH +: 8];
            s2_y_reg     <= y_sum[16:8];
            s2_cb_reg    <= cb_sum[17:8];
            s2_cr_reg    <= cr_sum[17:8];
        end
    end

    // ---------------- stage 3: clamps, mixer, output register ----------------
    logic [7:0] s3_first_reg, s3_second_reg, s3_third_reg, s3_alpha_reg;
    logic       s3_last_reg;

    logic signed [11:0] alpha_sum;
    logic signed [11:0] corr;
    logic [7:0]         alpha_sat;
    logic [7:0]         alpha_next;
    logic signed [9:0]  y_off, cb_off, cr_off;
    logic [7:0]         first_next, second_next, third_next;

    assign corr      = gain_reg[8] ? -$signed(12'(s2_q100_reg)) : $signed(12'(s2_q100_reg));
    assign alpha_sum = $signed(12'(s2_alpha_reg)) + corr + 12'(offset_reg);
    assign alpha_sat = (alpha_sum < 0) ? 8'd0 :
                       (alpha_sum > 12'sd255) ? 8'd255 : alpha_sum[7:0];
    assign alpha_next = (mix && mixer_fade_reg) ? {1'b0, alpha_sat[7:1]} : alpha_sat;

    assign y_off  = $signed(10'(s2_y_reg)) + $signed(pay_pkg::Y_OFFSET);
    assign cb_off = s2_cb_reg + $signed(pay_pkg::C_OFFSET);
    assign cr_off = s2_cr_reg + $signed(pay_pkg::C_OFFSET);

    always_comb
    begin
        if (rgb_output_reg)
        begin
            if (mix && mixer_gray_reg)
            begin
                first_next  = s2_avg_reg;
                second_next = s2_avg_reg;
                third_next  = s2_avg_reg;
            end
            else
            begin
                first_next  = s2_red_reg;
                second_next = s2_green_reg;
                third_next  = s2_blue_reg;
            end
        end
        else
        begin
            first_next = pay_pkg::clamp10(y_off, pay_pkg::Y_MIN, pay_pkg::Y_MAX);
            if (mix && mixer_gray_reg)
            begin
                second_next = pay_pkg::C_GRAY;
                third_next  = pay_pkg::C_GRAY;
            end
            else
            begin
                second_next = pay_pkg::clamp10(cb_off, pay_pkg::C_MIN, pay_pkg::C_MAX);
                third_next  = pay_pkg::clamp10(cr_off, pay_pkg::C_MIN, pay_pkg::C_MAX);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_first_reg  <= first_next;
            s3_second_reg <= second_next;
            s3_third_reg  <= third_next;
            s3_alpha_reg  <= alpha_next;
            s3_last_reg   <= s2_last_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign out_first  = s3_first_reg;
    assign out_second = s3_second_reg;
    assign out_third  = s3_third_reg;
    assign out_alpha  = s3_alpha_reg;
    assign out_last   = s3_last_reg;

endmodule

`default_nettype wire
